[sv/mpe_pkg.sv]
// Shared types, constants and helpers for the Mandelbrot pixel engine.
package mpe_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned FixW    = 32;
  localparam int unsigned IterW   = 16;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QDepth  = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_REAL  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_IMAG  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_REAL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_IMAG = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ITER  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INV_ITER  = 3'd5;

  localparam logic [64:0] EscapeLimit = 65'd1 << 60;
  localparam logic [31:0] OneQ30      = 32'd1 << 30;
  localparam logic [31:0] RedScale    = 32'd2295;
  localparam logic [31:0] GreenScale  = 32'd3825;
  localparam logic [31:0] BlueScale   = 32'd4335;
  localparam logic [3:0]  LastCStep   = 4'd12;

  typedef struct packed {
    logic signed [FixW-1:0] cr;
    logic signed [FixW-1:0] ci;
  } point_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_ADD, B_COLOR, B_EMIT
  } back_state_t;

  // saturate a wide signed value to the Q3.29 range
  function automatic logic signed [FixW-1:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd2147483647;
    lo = -48'sd2147483648;
    if (v > hi) return hi[FixW-1:0];
    if (v < lo) return lo[FixW-1:0];
    return v[FixW-1:0];
  endfunction

  function automatic logic [ColorW-1:0] clamp255(input logic [33:0] v);
    return (v > 34'd255) ? 8'd255 : v[ColorW-1:0];
  endfunction

endpackage

[sv/mpe_if.sv]
// Handshake channel interfaces: pixel input, color output, register write.
interface mpe_in_if;
  import mpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] column;
  logic [CoordW-1:0] row;
  modport source (output valid, column, row, input ready);
  modport sink (input valid, column, row, output ready);
endinterface

interface mpe_out_if;
  import mpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;
  logic [IterW-1:0]  iterations;
  modport source (output valid, red, green, blue, iterations, input ready);
  modport sink (input valid, red, green, blue, iterations, output ready);
endinterface

interface mpe_cfg_if;
  import mpe_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [FixW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/mpe_front.sv]
// Front end: clamp pixel coordinates and map them to a complex point.
module mpe_front
  import mpe_pkg::*;
#(
  parameter int unsigned COLUMNS = 4096,
  parameter int unsigned ROWS    = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CoordW-1:0]      column,
  input  logic [CoordW-1:0]      row,
  input  logic signed [FixW-1:0] min_real,
  input  logic signed [FixW-1:0] min_imag,
  input  logic signed [FixW-1:0] step_real,
  input  logic signed [FixW-1:0] step_imag,
  output logic                   push_valid,
  input  logic                   push_ready,
  output point_t                 push_data
);

  localparam logic [16:0] ColMax = 17'(COLUMNS - 1);
  localparam logic [16:0] RowMax = 17'(ROWS - 1);

  logic                   stage_valid_r;
  logic signed [44:0]     prod_re_r;
  logic signed [44:0]     prod_im_r;
  logic [CoordW-1:0]      col_c;
  logic [CoordW-1:0]      row_c;

  assign col_c = ({5'd0, column} > ColMax) ? ColMax[CoordW-1:0] : column;
  assign row_c = ({5'd0, row} > RowMax) ? RowMax[CoordW-1:0] : row;

  assign in_ready   = !stage_valid_r || push_ready;
  assign push_valid = stage_valid_r;
  assign push_data.cr = sat32(48'(min_real) + 48'(prod_re_r));
  assign push_data.ci = sat32(48'(min_imag) + 48'(prod_im_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_re_r <= $signed({1'b0, col_c}) * step_real;
      prod_im_r <= $signed({1'b0, row_c}) * step_imag;
    end
  end

endmodule

[sv/mpe_queue.sv]
// Short point queue between the front end and the iteration engine.
module mpe_queue
  import mpe_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  point_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output point_t pop_data
);

  localparam int unsigned PtrW = $clog2(QDepth);

  point_t            mem_r [QDepth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [PtrW:0]     fill_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill_r != (PtrW+1)'(QDepth));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) fill_r <= fill_r + 1'b1;
      else if (do_pop && !do_push) fill_r <= fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[sv/mpe_back.sv]
// Back end: escape-time iteration, Bernstein coloring and output register.
module mpe_back
  import mpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  point_t             pop_data,
  input  logic [IterW-1:0]   iter_cap,
  input  logic [31:0]        inv_iter_cap,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ColorW-1:0]  red,
  output logic [ColorW-1:0]  green,
  output logic [ColorW-1:0]  blue,
  output logic [IterW-1:0]   iterations
);

  back_state_t state_r, state_nxt;

  logic signed [FixW-1:0] cr_r, ci_r, zr_r, zi_r;
  logic [IterW-1:0]       count_r;
  logic signed [63:0]     sr_r, si_r, pr_r;
  logic [3:0]             cstep_r;
  logic [63:0]            prod_r;
  logic [31:0]            t_r, u_r, t2_r, t3_r, u2_r, u3_r;
  logic [ColorW-1:0]      red_r, green_r, blue_r;
  logic                   out_valid_r;
  logic [ColorW-1:0]      out_red_r, out_green_r, out_blue_r;
  logic [IterW-1:0]       out_iter_r;

  logic [64:0]            mag;
  logic signed [63:0]     diff;
  logic signed [47:0]     nr_w, ni_w;
  logic                   escape;
  logic                   at_limit;
  logic [31:0]            op_a, op_b;
  logic [31:0]            prod_q30;
  logic [45:0]            t_raw;
  logic                   slot_free;

  assign mag      = {1'b0, sr_r} + {1'b0, si_r};
  assign escape   = mag > EscapeLimit;
  assign diff     = sr_r - si_r;
  assign nr_w     = 48'(signed'(diff[63:29])) + 48'(cr_r);
  assign ni_w     = 48'(signed'(pr_r[63:28])) + 48'(ci_r);
  assign at_limit = (count_r == iter_cap);
  assign prod_q30 = prod_r[61:30];
  assign t_raw    = prod_r[47:2];
  assign slot_free = !out_valid_r || out_ready;

  assign pop_ready  = (state_r == B_IDLE);
  assign out_valid  = out_valid_r;
  assign red        = out_red_r;
  assign green      = out_green_r;
  assign blue       = out_blue_r;
  assign iterations = out_iter_r;

  // shared color multiplier operands, one product per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cstep_r)
      4'd0:  begin op_a = 32'(count_r); op_b = inv_iter_cap; end
      4'd2:  begin op_a = t_r;         op_b = t_r;          end
      4'd3:  begin op_a = prod_q30;    op_b = t_r;          end
      4'd4:  begin op_a = u_r;         op_b = u_r;          end
      4'd5:  begin op_a = prod_q30;    op_b = u_r;          end
      4'd6:  begin op_a = u_r;         op_b = t3_r;         end
      4'd7:  begin op_a = prod_q30;    op_b = RedScale;     end
      4'd8:  begin op_a = u2_r;        op_b = t2_r;         end
      4'd9:  begin op_a = prod_q30;    op_b = GreenScale;   end
      4'd10: begin op_a = u3_r;        op_b = t_r;          end
      4'd11: begin op_a = prod_q30;    op_b = BlueScale;    end
      default: begin op_a = '0;        op_b = '0;           end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (pop_valid) state_nxt = B_MUL;
      B_MUL:   state_nxt = at_limit ? B_EMIT : B_ADD;
      B_ADD:   state_nxt = escape ? B_COLOR : B_MUL;
      B_COLOR: if (cstep_r == LastCStep) state_nxt = B_EMIT;
      B_EMIT:  if (slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        cr_r    <= pop_data.cr;
        ci_r    <= pop_data.ci;
        zr_r    <= '0;
        zi_r    <= '0;
        count_r <= '0;
        cstep_r <= '0;
      end
      B_MUL: begin
        sr_r    <= zr_r * zr_r;
        si_r    <= zi_r * zi_r;
        pr_r    <= zr_r * zi_r;
        red_r   <= '0;
        green_r <= '0;
        blue_r  <= '0;
      end
      B_ADD: begin
        if (!escape) begin
          zr_r    <= sat32(nr_w);
          zi_r    <= sat32(ni_w);
          count_r <= count_r + 1'b1;
        end
      end
      B_COLOR: begin
        cstep_r <= cstep_r + 1'b1;
        prod_r  <= op_a * op_b;
        case (cstep_r)
          4'd1: begin
            t_r <= (t_raw > 46'(OneQ30)) ? OneQ30 : t_raw[31:0];
            u_r <= OneQ30 - ((t_raw > 46'(OneQ30)) ? OneQ30 : t_raw[31:0]);
          end
          4'd3:  t2_r    <= prod_q30;
          4'd4:  t3_r    <= prod_q30;
          4'd5:  u2_r    <= prod_q30;
          4'd6:  u3_r    <= prod_q30;
          4'd8:  red_r   <= clamp255(prod_r[63:30]);
          4'd10: green_r <= clamp255(prod_r[63:30]);
          4'd12: blue_r  <= clamp255({1'b0, prod_r[63:31]});
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_EMIT && slot_free) begin
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
      out_iter_r  <= count_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ADD) |-> (count_r < iter_cap))
    else $error("iteration count reached limit inside iteration");
  a_cstep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_COLOR) |-> (cstep_r <= LastCStep))
    else $error("color step counter overran");
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT && slot_free) |=> out_valid_r)
    else $error("finished pixel not presented");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> (state_r == B_MUL))
    else $error("popped point did not start iterating");

endmodule

[sv/mandelbrot_pixel_engine.sv]
// Top level: register file, front end, point queue and iteration back end.
//
//  Channel   Dir  Fields                              Accepted when
//  cfg_wr    in   index[2:0], data[31:0]             valid & ready (ready always 1)
//  in_px     in   column[11:0], row[11:0]             valid & ready
//  out_px    out  red, green, blue[7:0], iterations   valid & ready
//
// The back end runs each iteration as a multiply state, then an escape test
// and add state. A point that reaches the limit goes from the multiply state
// to the output load; one that escapes goes through the failing escape test,
// then 13 steps on the one shared color multiplier, then the output load.
// The mapping stage registers its step products; a full output register holds
// the back end in its load state until the word is taken.
// The front end maps the next pixel while the back end iterates; a two-word
// queue and the output register let either side stall on its own.
// Reset (rst_n low, synchronous) loads the default view and empties all words.
module mandelbrot_pixel_engine
  import mpe_pkg::*;
#(
  parameter int unsigned COLUMNS = 4096,
  parameter int unsigned ROWS    = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  mpe_cfg_if.sink    cfg_wr,
  mpe_in_if.sink     in_px,
  mpe_out_if.source  out_px
);

  logic signed [FixW-1:0] min_real_r, min_imag_r, step_real_r, step_imag_r;
  logic [IterW-1:0]       iter_cap_r;
  logic [31:0]            inv_iter_cap_r;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  point_t push_data, pop_data;

  // the user must write only while idle (the block does not enforce it); take them every cycle
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_real_r     <= -32'sd1073741824;
      min_imag_r     <= -32'sd536870912;
      step_real_r    <= 32'sd419540;
      step_imag_r    <= 32'sd497334;
      iter_cap_r     <= 16'd1000;
      inv_iter_cap_r <= 32'd4294967;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_MIN_REAL:  min_real_r     <= cfg_wr.data;
        CFG_MIN_IMAG:  min_imag_r     <= cfg_wr.data;
        CFG_STEP_REAL: step_real_r    <= cfg_wr.data;
        CFG_STEP_IMAG: step_imag_r    <= cfg_wr.data;
        CFG_MAX_ITER:  iter_cap_r     <= cfg_wr.data[IterW-1:0];
        CFG_INV_ITER:  inv_iter_cap_r <= cfg_wr.data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // map coordinates to a complex point
  mpe_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_px.valid),
    .in_ready   (in_px.ready),
    .column     (in_px.column),
    .row        (in_px.row),
    .min_real   (min_real_r),
    .min_imag   (min_imag_r),
    .step_real  (step_real_r),
    .step_imag  (step_imag_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // hold mapped points until the back end is free
  mpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // iterate, color and present the result word
  mpe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .iter_cap     (iter_cap_r),
    .inv_iter_cap (inv_iter_cap_r),
    .out_valid    (out_px.valid),
    .out_ready    (out_px.ready),
    .red          (out_px.red),
    .green        (out_px.green),
    .blue         (out_px.blue),
    .iterations   (out_px.iterations)
  );

endmodule

[bench/tb_mandelbrot_pixel_engine.sv]
// Self-checking testbench for the Mandelbrot pixel engine: escape counts and colors.
module tb_mandelbrot_pixel_engine;
  import mpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Grid size of the instance; coordinates past it clamp to the last column/row.
  localparam int unsigned GRID_COLUMNS = 4096;
  localparam int unsigned GRID_ROWS    = 4096;
  // Indexes past the register list; the block must drop writes to them.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  // Generous ceiling on the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  // Q3.29 value of 1.0, used to place random windows near the set.
  localparam longint ONE_Q29 = 64'sd1 << 29;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [IterW-1:0]  iterations;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  mpe_cfg_if cfg_if ();
  mpe_in_if  in_if ();
  mpe_out_if out_if ();

  mandelbrot_pixel_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_if),
    .in_px  (in_if),
    .out_px (out_if)
  );

  // 2 ns period: one delay high, one low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the view registers, kept in step with every accepted write.
  longint          view_min_re;
  longint          view_min_im;
  longint          view_step_re;
  longint          view_step_im;
  int unsigned     iter_limit;
  longint unsigned iter_recip;

  // Colors the block still owes us, oldest first.
  pixel_t pending_pixels[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned inside_count;
  int unsigned views_used;
  int unsigned burst_left;

  // Clip a wide signed value to the Q3.29 range.
  function automatic longint clip_q29(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Escape-time iteration and Bernstein coloring for one pixel under the current view.
  function automatic pixel_t predict_pixel(input logic [CoordW-1:0] col_in,
                                           input logic [CoordW-1:0] row_in);
    longint          col;
    longint          row;
    longint          c_re;
    longint          c_im;
    longint          z_re;
    longint          z_im;
    longint          sq_re;
    longint          sq_im;
    longint          nxt_re;
    longint          nxt_im;
    longint unsigned t;
    longint unsigned u;
    longint unsigned t2;
    longint unsigned t3;
    longint unsigned u2;
    longint unsigned u3;
    longint unsigned shade;
    int unsigned     count;
    pixel_t          px;
    col = (col_in > GRID_COLUMNS - 1) ? GRID_COLUMNS - 1 : col_in;
    row = (row_in > GRID_ROWS - 1) ? GRID_ROWS - 1 : row_in;
    c_re = clip_q29(view_min_re + col * view_step_re);
    c_im = clip_q29(view_min_im + row * view_step_im);
    z_re = 0;
    z_im = 0;
    count = 0;
    while (count < iter_limit) begin
      sq_re = z_re * z_re;
      sq_im = z_im * z_im;
      if (64'(unsigned'(sq_re)) + 64'(unsigned'(sq_im)) > (64'd1 << 60)) break;
      nxt_re = clip_q29(((sq_re - sq_im) >>> 29) + c_re);
      nxt_im = clip_q29(((z_re * z_im) >>> 28) + c_im);
      z_re = nxt_re;
      z_im = nxt_im;
      count++;
    end
    px = '0;
    px.iterations = count[IterW-1:0];
    if (count != iter_limit) begin
      t = (longint'(count) * iter_recip) >> 2;
      if (t > (64'd1 << 30)) t = 64'd1 << 30;
      u  = (64'd1 << 30) - t;
      t2 = (t * t) >> 30;
      t3 = (t2 * t) >> 30;
      u2 = (u * u) >> 30;
      u3 = (u2 * u) >> 30;
      shade = (64'd2295 * ((u * t3) >> 30)) >> 30;
      px.red = (shade > 255) ? 8'd255 : shade[7:0];
      shade = (64'd3825 * ((u2 * t2) >> 30)) >> 30;
      px.green = (shade > 255) ? 8'd255 : shade[7:0];
      shade = (64'd4335 * ((u3 * t) >> 30)) >> 31;
      px.blue = (shade > 255) ? 8'd255 : shade[7:0];
    end
    return px;
  endfunction

  // Write one register and mirror it into the local view.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [FixW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MIN_REAL:  view_min_re  = longint'(signed'(value));
      CFG_MIN_IMAG:  view_min_im  = longint'(signed'(value));
      CFG_STEP_REAL: view_step_re = longint'(signed'(value));
      CFG_STEP_IMAG: view_step_im = longint'(signed'(value));
      CFG_MAX_ITER:  iter_limit   = {16'd0, value[IterW-1:0]};
      CFG_INV_ITER:  iter_recip   = 64'(value);
      default: ;
    endcase
  endtask

  task automatic load_view(input logic [FixW-1:0] min_re, input logic [FixW-1:0] min_im,
                           input logic [FixW-1:0] step_re, input logic [FixW-1:0] step_im,
                           input logic [FixW-1:0] limit, input logic [FixW-1:0] recip);
    write_register(CFG_MIN_REAL, min_re);
    write_register(CFG_MIN_IMAG, min_im);
    write_register(CFG_STEP_REAL, step_re);
    write_register(CFG_STEP_IMAG, step_im);
    write_register(CFG_MAX_ITER, limit);
    write_register(CFG_INV_ITER, recip);
    views_used++;
  endtask

  // Hold valid until the pixel is taken, then queue its predicted color.
  // Valid stays high afterwards; pace_sender or drop_valid decides whether to drop it.
  task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] row);
    pixel_t px;
    in_if.valid  <= 1'b1;
    in_if.column <= col;
    in_if.row    <= row;
    do @(posedge clk); while (!in_if.ready);
    px = predict_pixel(col, row);
    pending_pixels.push_back(px);
    pixels_sent++;
    if (px.iterations == iter_limit) inside_count++;
  endtask

  // Bursts of random length, separated by random gaps.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let every owed pixel come back; the block is idle after that.
  task automatic drain();
    drop_valid();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random window that covers a useful part of the set, mostly with a matching reciprocal.
  task automatic load_random_view(input int unsigned limit_max);
    logic [FixW-1:0] limit;
    logic [FixW-1:0] recip;
    longint          re0;
    longint          im0;
    limit = $urandom_range(1, limit_max);
    recip = (limit == 1) ? 32'hFFFF_FFFF : 32'((64'd1 << 32) / limit);
    if ($urandom_range(0, 7) == 0) recip = $urandom;
    re0 = -(5 * ONE_Q29) / 2 + longint'($urandom_range(0, 3 * 536870912));
    im0 = -(3 * ONE_Q29) / 2 + longint'($urandom_range(0, 2 * 536870912));
    load_view(32'(re0), 32'(im0), $urandom_range(1, 1200000), $urandom_range(1, 1200000),
              limit, recip);
  endtask

  // Directed pixels under the reset view: grid corners, alternating bit patterns and one interior point.
  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'd2048, 12'd1080);
    drain();
  endtask

  // Register extremes: saturated points, zero and one iteration, reciprocal clamp,
  // writes to spare indexes.
  task automatic test_register_extremes();
    load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'd1000, 32'd4294967);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
    load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'd0, 32'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'h001);
    drain();
    // One iteration with a reciprocal of all ones.
    load_view(32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
    // Spare indexes are ignored: view below must still be in force.
    load_view(-32'sd1073741824, -32'sd268435456, 32'd262144, 32'd131072,
              32'd40, 32'd107374182);
    write_register(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_register(CFG_SPARE_HI, 32'h1234_5678);
    for (int i = 0; i < 6; i++) send_pixel(12'(i * 700), 12'(i * 300));
    drain();
  endtask

  // Largest iteration limit with one point that never escapes, then two pixels under a limit of 3000.
  task automatic test_deep_iteration();
    load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF, 32'd65537);
    send_pixel(12'd5, 12'd9);
    drain();
    load_view(-32'sd1073741824, 32'd0, 32'd8192, 32'd8192, 32'd3000, 32'd1431655);
    send_pixel(12'd100, 12'd200);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
  endtask

  // Random views, mostly small limits, random pixels, paced bursts.
  task automatic test_random_views(input int unsigned views, input int unsigned per_view);
    for (int v = 0; v < views; v++) begin
      if (v % 5 == 4) begin
        // Noise view: all registers random, limit kept small.
        load_view($urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 60), $urandom);
      end else begin
        load_random_view((v % 3 == 0) ? 200 : 48);
      end
      for (int i = 0; i < per_view; i++) begin
        send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        // On some views, hold off mid-view until every owed pixel has come back.
        if (i == per_view / 2 && v % 4 == 1) begin
          drop_valid();
          while (pending_pixels.size() != 0) @(posedge clk);
        end else begin
          pace_sender();
        end
      end
      drain();
    end
  endtask

  // Receiver: pick a new stall pattern whenever cycle_count[6:0] is zero.
  int unsigned stall_mode;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[6:0] == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= (cycle_count[3:0] < 4'd11);
    endcase
  end

  // Compare every accepted color with the oldest prediction.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.red, out_if.green, out_if.blue, out_if.iterations};
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected pixel word: r=%0d g=%0d b=%0d it=%0d",
                   got.red, got.green, got.blue, got.iterations);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"pixel %0d mismatch: exp r=%0d g=%0d b=%0d it=%0d,",
                      " got r=%0d g=%0d b=%0d it=%0d"},
                     pixels_checked, want.red, want.green, want.blue, want.iterations,
                     got.red, got.green, got.blue, got.iterations);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels owed", cycle_count,
               pending_pixels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cycle_count    = 0;
    mismatch_count = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    inside_count   = 0;
    views_used     = 0;
    burst_left     = 1;
    stall_mode     = 0;
    rst_n          = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    in_if.valid    = 1'b0;
    in_if.column   = '0;
    in_if.row      = '0;
    out_if.ready   = 1'b0;
    // Reset view.
    view_min_re  = -64'sd1073741824;
    view_min_im  = -64'sd536870912;
    view_step_re = 64'sd419540;
    view_step_im = 64'sd497334;
    iter_limit   = 1000;
    iter_recip   = 64'd4294967;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_view();
    test_register_extremes();
    test_deep_iteration();
    test_random_views(20, 28);

    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d views, %0d pixels sent, %0d checked, %0d inside the set.",
             views_used, pixels_sent, pixels_checked, inside_count);
    $display("Mismatches: %0d, cycles: %0d.", mismatch_count, cycle_count);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
